// ----- rtl/lcd_stripe_refresh_sequencer_core_macros.svh -----
// assertion macros shared by the stripe refresh sequencer rtl
`ifndef LCD_STRIPE_REFRESH_SEQUENCER_CORE_MACROS_SVH
`define LCD_STRIPE_REFRESH_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lss_pkg.sv -----
// shared constants, types, microcode table and helpers of the stripe refresh sequencer
package lss_pkg;

  localparam int unsigned STORE_SIZE     = 9600;
  localparam int unsigned ADDR_W         = 14;
  localparam int unsigned SUM_W          = ADDR_W + 1;
  localparam int unsigned STRIPES        = 10;
  localparam int unsigned STRIPE_W       = 4;
  localparam int unsigned STRIPE_BYTES   = 960;
  localparam int unsigned PIX_W          = 10;
  localparam int unsigned STRIPE_COLUMNS = 32;
  localparam int unsigned COL_W          = 16;
  localparam int unsigned STEP_W         = 4;

  // lcd command and parameter bytes
  localparam logic [7:0] CMD_PAGE_SET = 8'h44;
  localparam logic [7:0] CMD_COL_SET  = 8'hc4;
  localparam logic [7:0] CMD_WRITE    = 8'h5c;
  localparam logic [7:0] PAR_ZERO     = 8'h00;
  localparam logic [7:0] PAR_PAGE     = 8'hb8;
  localparam logic [7:0] PAR_TAIL     = 8'hA5;

  // microcode step where the frame byte loop sits
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FRAME = STEP_W'(12);

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_START_HI,
    SRC_START_LO,
    SRC_END_HI,
    SRC_END_LO,
    SRC_STORE
  } src_e;

  typedef enum logic {
    JMP_NEXT,
    JMP_PIXEL_LOOP
  } jmp_e;

  // one control word of the refresh program
  typedef struct packed {
    logic              is_data;
    src_e              src;
    logic [7:0]        lit;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // frame store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // transfer described by the current step
  typedef struct packed {
    logic              is_data;
    logic              from_store;
    logic              in_range;
    logic [7:0]        lit;
    logic              done;
    logic [ADDR_W-1:0] rd_addr;
  } xfer_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[b] = v[7-b];
    end
    return r;
  endfunction

  function automatic ucode_t mk_word(input logic is_data, input src_e src,
                                     input logic [7:0] lit, input jmp_e jmp,
                                     input logic [STEP_W-1:0] target);
    ucode_t w;
    w.is_data = is_data;
    w.src     = src;
    w.lit     = lit;
    w.jmp     = jmp;
    w.target  = target;
    return w;
  endfunction

  // refresh program, one word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_W'(0):  w = mk_word(1'b0, SRC_LIT, CMD_PAGE_SET, JMP_NEXT, STEP_FIRST);
      STEP_W'(1):  w = mk_word(1'b1, SRC_LIT, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(2):  w = mk_word(1'b1, SRC_LIT, PAR_PAGE, JMP_NEXT, STEP_FIRST);
      STEP_W'(3):  w = mk_word(1'b1, SRC_LIT, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(4):  w = mk_word(1'b1, SRC_LIT, PAR_TAIL, JMP_NEXT, STEP_FIRST);
      STEP_W'(5):  w = mk_word(1'b0, SRC_LIT, CMD_COL_SET, JMP_NEXT, STEP_FIRST);
      STEP_W'(6):  w = mk_word(1'b1, SRC_START_HI, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(7):  w = mk_word(1'b1, SRC_START_LO, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(8):  w = mk_word(1'b1, SRC_END_HI, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(9):  w = mk_word(1'b1, SRC_END_LO, PAR_ZERO, JMP_NEXT, STEP_FIRST);
      STEP_W'(10): w = mk_word(1'b0, SRC_LIT, CMD_WRITE, JMP_NEXT, STEP_FIRST);
      STEP_W'(11): w = mk_word(1'b1, SRC_LIT, PAR_TAIL, JMP_NEXT, STEP_FIRST);
      STEP_FRAME:  w = mk_word(1'b1, SRC_STORE, PAR_ZERO, JMP_PIXEL_LOOP, STEP_FIRST);
      default:     w = mk_word(1'b1, SRC_STORE, PAR_ZERO, JMP_PIXEL_LOOP, STEP_FIRST);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lcd_stripe_refresh_sequencer_core.sv -----
// top level: input decode, read stage and output register of the stripe refresh sequencer
// a tick's transfer is held in the read stage register, then moves to the output register when it is free
// throughput: one item per cycle unless the output stalls; a tick's frame byte read is one read port access
// a write item gives no result and is written at its transfer edge, so the next tick sees it
// reset clears the counters, then a sweep zeroes all 9600 entries of the frame store
// and no input is taken until the sweep ends
`include "lcd_stripe_refresh_sequencer_core_macros.svh"

module lcd_stripe_refresh_sequencer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [lss_pkg::ADDR_W-1:0] store_address_i,
  input  logic [7:0]                 store_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_data_o,
  output logic [7:0]                 bus_byte_o,
  output logic                       stripe_done_o
);

  lss_pkg::xfer_t     xfer;
  lss_pkg::store_wr_t wr;
  logic               store_ready;
  logic [7:0]         rd_data;
  logic               in_xfer, tick, rd_en;

  logic       s1_valid_q, s1_valid_d;
  logic       s1_is_data_q, s1_from_store_q, s1_in_range_q, s1_done_q;
  logic [7:0] s1_lit_q;
  logic       s1_adv;

  logic       out_valid_q, out_valid_d;
  logic       out_is_data_q, out_done_q;
  logic [7:0] out_byte_q;
  logic [7:0] s1_byte;

  // input transfer decode
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = store_ready & (~s1_valid_q | s1_adv);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign tick       = in_xfer & kind_i;
  assign rd_en      = tick & xfer.from_store & xfer.in_range;

  assign wr.en   = in_xfer & ~kind_i &
                   (store_address_i < lss_pkg::ADDR_W'(lss_pkg::STORE_SIZE));
  assign wr.addr = store_address_i;
  assign wr.data = store_byte_i;

  lss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .xfer_o (xfer)
  );

  lss_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (xfer.rd_addr),
    .rd_data_o (rd_data),
    .ready_o   (store_ready)
  );

  // read stage: control captured while the frame byte is read
  assign s1_valid_d = tick | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_is_data_q    <= xfer.is_data;
      s1_from_store_q <= xfer.from_store;
      s1_in_range_q   <= xfer.in_range;
      s1_lit_q        <= xfer.lit;
      s1_done_q       <= xfer.done;
    end
  end

  // frame bytes go out bit-reversed, out-of-store reads as zero
  always_comb begin
    if (!s1_from_store_q) begin
      s1_byte = s1_lit_q;
    end else if (s1_in_range_q) begin
      s1_byte = lss_pkg::rev8(rd_data);
    end else begin
      s1_byte = 8'h00;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_is_data_q <= s1_is_data_q;
      out_byte_q    <= s1_byte;
      out_done_q    <= s1_done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_data_o     = out_is_data_q;
  assign bus_byte_o    = out_byte_q;
  assign stripe_done_o = out_done_q;

  // checks
  `LSS_ASSERT_IMP(a_done_is_data, out_valid_o && stripe_done_o, is_data_o,
    "stripe end flagged on a command byte")
  `LSS_ASSERT_IMP(a_idle_while_clearing, !store_ready, !s1_valid_q && !out_valid_q,
    "transfer in flight during frame store clear")
  `LSS_ASSERT_NXT(a_stage_holds, s1_valid_q && out_valid_q && !out_ready_i,
    s1_valid_q && out_valid_q, "read stage dropped or overrun while output stalled")

endmodule

// ----- rtl/lss_store.sv -----
// frame store memory with a clearing sweep after reset
module lss_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lss_pkg::store_wr_t            wr_i,
  input  logic                          rd_en_i,
  input  logic [lss_pkg::ADDR_W-1:0]    rd_addr_i,
  output logic [7:0]                    rd_data_o,
  output logic                          ready_o
);

  logic [7:0]                 mem [lss_pkg::STORE_SIZE];
  logic [lss_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic                       clearing_q, clearing_d;
  logic [7:0]                 rd_data_q;

  // clear sweep, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_addr_q == lss_pkg::ADDR_W'(lss_pkg::STORE_SIZE - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = lss_pkg::ADDR_W'(clr_addr_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clearing_q;

endmodule

// ----- rtl/lss_seq.sv -----
// microcoded step sequencer: step counter, pixel loop and stripe counters
module lss_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_i,
  output lss_pkg::xfer_t xfer_o
);

  logic [lss_pkg::STEP_W-1:0]   step_q, step_d;
  logic [lss_pkg::PIX_W-1:0]    pixel_q, pixel_d;
  logic [lss_pkg::STRIPE_W-1:0] stripe_q, stripe_d;
  logic [lss_pkg::ADDR_W-1:0]   base_q, base_d;

  lss_pkg::ucode_t           word;
  logic [lss_pkg::COL_W-1:0] start_col, end_col;
  logic [lss_pkg::SUM_W-1:0] addr_sum;
  logic                      pixel_last;
  logic                      stripe_last;
  logic [7:0]                src_byte;

  assign word        = lss_pkg::ucode_rom(step_q);
  assign start_col   = lss_pkg::COL_W'(32'(stripe_q) * lss_pkg::STRIPE_COLUMNS);
  assign end_col     = lss_pkg::COL_W'(start_col + lss_pkg::COL_W'(lss_pkg::STRIPE_COLUMNS - 1));
  assign addr_sum    = lss_pkg::SUM_W'(base_q) + lss_pkg::SUM_W'(pixel_q);
  assign pixel_last  = (pixel_q == lss_pkg::PIX_W'(lss_pkg::STRIPE_BYTES - 1));
  assign stripe_last = (stripe_q == lss_pkg::STRIPE_W'(lss_pkg::STRIPES - 1));

  // byte source select of the control word
  always_comb begin
    unique case (word.src)
      lss_pkg::SRC_LIT:      src_byte = word.lit;
      lss_pkg::SRC_START_HI: src_byte = lss_pkg::rev8(start_col[15:8]);
      lss_pkg::SRC_START_LO: src_byte = lss_pkg::rev8(start_col[7:0]);
      lss_pkg::SRC_END_HI:   src_byte = lss_pkg::rev8(end_col[15:8]);
      lss_pkg::SRC_END_LO:   src_byte = lss_pkg::rev8(end_col[7:0]);
      lss_pkg::SRC_STORE:    src_byte = 8'h00;
      default:               src_byte = 8'h00;
    endcase
  end

  assign xfer_o.is_data    = word.is_data;
  assign xfer_o.from_store = (word.src == lss_pkg::SRC_STORE);
  assign xfer_o.in_range   = (addr_sum < lss_pkg::SUM_W'(lss_pkg::STORE_SIZE));
  assign xfer_o.lit        = src_byte;
  assign xfer_o.done       = (word.jmp == lss_pkg::JMP_PIXEL_LOOP) && pixel_last;
  assign xfer_o.rd_addr    = addr_sum[lss_pkg::ADDR_W-1:0];

  // step advance and conditional jump at the end of the pixel loop
  always_comb begin
    step_d   = step_q;
    pixel_d  = pixel_q;
    stripe_d = stripe_q;
    base_d   = base_q;
    if (tick_i) begin
      unique case (word.jmp)
        lss_pkg::JMP_NEXT: begin
          step_d = lss_pkg::STEP_W'(step_q + 1'b1);
        end
        lss_pkg::JMP_PIXEL_LOOP: begin
          if (pixel_last) begin
            step_d  = word.target;
            pixel_d = '0;
            if (stripe_last) begin
              stripe_d = '0;
              base_d   = '0;
            end else begin
              stripe_d = lss_pkg::STRIPE_W'(stripe_q + 1'b1);
              base_d   = lss_pkg::ADDR_W'(base_q + lss_pkg::ADDR_W'(lss_pkg::STRIPE_BYTES));
            end
          end else begin
            pixel_d = lss_pkg::PIX_W'(pixel_q + 1'b1);
          end
        end
        default: begin
          step_d = step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      pixel_q  <= '0;
      stripe_q <= '0;
      base_q   <= '0;
    end else begin
      step_q   <= step_d;
      pixel_q  <= pixel_d;
      stripe_q <= stripe_d;
      base_q   <= base_d;
    end
  end

endmodule
